[src/token_bucket_wait_calculator_macros.svh]
// Assertion macros shared by the token bucket wait calculator modules.
`ifndef TOKEN_BUCKET_WAIT_CALCULATOR_MACROS_SVH
`define TOKEN_BUCKET_WAIT_CALCULATOR_MACROS_SVH

// Check that holds in the same cycle as its trigger.
`define TBWC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbwc: same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define TBWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbwc: next-cycle check failed");

`endif

[src/tbwc_pkg.sv]
// Package of the token bucket wait calculator: widths, codes, state and control types.
`default_nettype none

package tbwc_pkg;

  localparam int RATE_W           = 20;
  localparam int BYTES_W          = 32;
  localparam int WAIT_W           = 32;
  localparam int KB_SHIFT         = 10;
  localparam int TPS_DEFAULT      = 1024;
  localparam int BURST_DEFAULT    = 2;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CFG,
    S_TICK,
    S_CONS,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic item_load;
    logic cfg_load;
    logic cfg_apply;
    logic tick;
    logic consume;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic unlimited;
    logic covered;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

[src/tbwc_dp.sv]
// Datapath: bucket level, cap, cost, restoring divider and result registers.
`default_nettype none
`include "token_bucket_wait_calculator_macros.svh"

module tbwc_dp #(
  parameter int TICKS_PER_SECOND = tbwc_pkg::TPS_DEFAULT,
  parameter int BURST_SECONDS    = tbwc_pkg::BURST_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tbwc_pkg::dp_cmd_t            cmd,
  output tbwc_pkg::dp_status_t              status,
  input  wire logic [tbwc_pkg::BYTES_W-1:0] byte_count,
  input  wire logic [tbwc_pkg::RATE_W-1:0]  rate_kb_per_sec,
  output logic      [tbwc_pkg::WAIT_W-1:0]  wait_ticks,
  output logic                              granted_now
);
  import tbwc_pkg::*;

  localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int COST_W   = BYTES_W + TPS_W;
  localparam int CAP_MUL  = (1 << KB_SHIFT) * TICKS_PER_SECOND * BURST_SECONDS;
  localparam int KW       = $clog2(CAP_MUL + 1);
  localparam int LEVEL_W  = RATE_W + KW;
  localparam int SUM_W    = LEVEL_W + 1;
  localparam int CMP_W    = (COST_W > LEVEL_W) ? COST_W : LEVEL_W;
  localparam int NQ       = COST_W - KB_SHIFT;
  localparam int CNT_W    = $clog2(NQ + 1);
  localparam int QX_W     = ((NQ > WAIT_W) ? NQ : WAIT_W) + 1;

  localparam logic [TPS_W-1:0] TPS_K = TPS_W'(TICKS_PER_SECOND);
  localparam logic [KW-1:0]    CAP_K = KW'(CAP_MUL);

  logic [RATE_W-1:0]  rate;
  logic [LEVEL_W-1:0] cap;
  logic               unl;
  logic [LEVEL_W-1:0] level;
  logic [COST_W-1:0]  cost;
  logic [RATE_W-1:0]  rem;
  logic [NQ-1:0]      quo;
  logic [CNT_W-1:0]   cnt;
  logic               res_grant;

  logic [COST_W-1:0]  cost_in;
  logic [LEVEL_W-1:0] cap_in;
  logic [SUM_W-1:0]   tick_sum;
  logic [CMP_W:0]     diff_m1;
  logic [CMP_W-1:0]   left_over;
  logic [RATE_W:0]    trial;
  logic               trial_ge;
  logic [QX_W-1:0]    q_inc;
  logic [WAIT_W-1:0]  wait_sat;

  assign cost_in = {{TPS_W{1'b0}}, byte_count} * {{BYTES_W{1'b0}}, TPS_K};
  assign cap_in  = {{KW{1'b0}}, rate_kb_per_sec} * {{RATE_W{1'b0}}, CAP_K};

  assign tick_sum = {1'b0, level} + SUM_W'({rate, {KB_SHIFT{1'b0}}});

  // cost + ~level is cost - level - 1; its carry says the level falls short
  assign diff_m1   = {1'b0, CMP_W'(cost)} + {1'b0, ~CMP_W'(level)};
  assign left_over = CMP_W'(level) - CMP_W'(cost);

  assign trial    = {rem, quo[NQ-1]};
  assign trial_ge = trial >= {1'b0, rate};

  // wait = floor((deficit - 1) / per_tick) + 1, clamped to the field
  assign q_inc    = QX_W'(quo) + QX_W'(1);
  assign wait_sat = (q_inc > QX_W'({WAIT_W{1'b1}})) ? {WAIT_W{1'b1}} : q_inc[WAIT_W-1:0];

  assign status.unlimited = unl;
  assign status.covered   = !diff_m1[CMP_W];
  assign status.div_last  = cnt == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= '0;
      cap   <= '0;
      unl   <= 1'b1;
      level <= '0;
    end else begin
      if (cmd.cfg_load) begin
        rate <= rate_kb_per_sec;
        cap  <= cap_in;
      end
      if (cmd.cfg_apply) begin
        if (rate == '0) begin
          unl <= 1'b1;
        end else begin
          if (unl || level > cap) begin
            level <= cap;
          end
          unl <= 1'b0;
        end
      end
      if (cmd.tick && !unl) begin
        level <= (tick_sum > {1'b0, cap}) ? cap : tick_sum[LEVEL_W-1:0];
      end
      if (cmd.consume && !unl) begin
        if (status.covered) begin
          level <= left_over[LEVEL_W-1:0];
        end else begin
          level <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      cost <= cost_in;
    end
    if (cmd.consume) begin
      res_grant <= unl || status.covered;
      rem       <= '0;
      quo       <= diff_m1[COST_W-1:KB_SHIFT];
      cnt       <= CNT_W'(NQ);
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? RATE_W'(trial - {1'b0, rate}) : trial[RATE_W-1:0];
      quo <= {quo[NQ-2:0], trial_ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.out_load) begin
      granted_now <= res_grant;
      wait_ticks  <= res_grant ? '0 : wait_sat;
    end
  end

  `TBWC_ASSERT_NEXT(a_tick_within_cap, clk, rst, cmd.tick, unl || level <= cap)
  `TBWC_ASSERT_NEXT(a_cfg_within_cap, clk, rst, cmd.cfg_apply, unl || level <= cap)
  `TBWC_ASSERT_NEXT(a_rem_below_rate, clk, rst, cmd.div_step, rem < rate)
  `TBWC_ASSERT_NEXT(a_grant_no_wait, clk, rst, cmd.out_load, !granted_now || wait_ticks == '0)

endmodule

`default_nettype wire

[src/tbwc_ctrl.sv]
// Controller: sequences config updates, ticks, consume checks, division and result hand-off.
`default_nettype none
`include "token_bucket_wait_calculator_macros.svh"

module tbwc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tbwc_pkg::dp_cmd_t         cmd,
  input  wire tbwc_pkg::dp_status_t status
);
  import tbwc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_next   = S_CFG;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = (kind == KIND_CONSUME) ? S_CONS : S_TICK;
        end
      end
      S_CFG: begin
        cmd.cfg_apply = 1'b1;
        state_next    = S_IDLE;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_IDLE;
      end
      S_CONS: begin
        cmd.consume = 1'b1;
        state_next  = (status.unlimited || status.covered) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `TBWC_ASSERT_NEXT(a_fin_holds, clk, rst, state == S_FIN && out_valid && out_stall, state == S_FIN)
  `TBWC_ASSERT_IMP(a_beat_from_fin, clk, rst, $rose(out_valid), $past(state) == S_FIN)
  `TBWC_ASSERT_NEXT(a_div_runs, clk, rst, state == S_DIV && !status.div_last, state == S_DIV)

endmodule

`default_nettype wire

[src/token_bucket_wait_calculator.sv]
// Top level of the token bucket wait calculator: controller and datapath.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -----------------------
//  in       sink       in_valid / in_stall    kind, byte_count
//  out      source     out_valid / out_stall  wait_ticks, granted_now
//  cfg      sink       cfg_valid / cfg_ready  rate_kb_per_sec
//
// A tick beat passes through S_TICK. A consume beat that is covered (or meets a
// disabled limiter) goes from S_CONS to S_FIN for its result; one that falls short
// first runs the one-bit-per-cycle restoring divider in S_DIV for 32 +
// clog2(TICKS_PER_SECOND+1) - 10 steps. A rate write passes through S_CFG.
// Reset (rst, synchronous) leaves the limiter disabled with rate zero.
// A result held under out_stall does not stop the next beat being taken; a
// consume beat then holds in its last step until the held result leaves.
// A config beat wins over an input beat offered in the same cycle.
`default_nettype none

module token_bucket_wait_calculator #(
  parameter int TICKS_PER_SECOND = tbwc_pkg::TPS_DEFAULT,
  parameter int BURST_SECONDS    = tbwc_pkg::BURST_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         kind,
  input  wire logic [tbwc_pkg::BYTES_W-1:0] byte_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tbwc_pkg::WAIT_W-1:0]  wait_ticks,
  output logic                              granted_now,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tbwc_pkg::RATE_W-1:0]  rate_kb_per_sec
);
  import tbwc_pkg::*;

  // Commands from the sequencer, flags back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  tbwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Level, cap and cost arithmetic plus the wait divider
  tbwc_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .BURST_SECONDS    (BURST_SECONDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .byte_count      (byte_count),
    .rate_kb_per_sec (rate_kb_per_sec),
    .wait_ticks      (wait_ticks),
    .granted_now     (granted_now)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the token bucket wait calculator: own bucket model, directed and random beats.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbwc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  // Quiet cycles tolerated before giving up. The longest correct quiet spell is the
  // long receiver hold (HOLD_CYCLES) plus a divide, a stall burst and a sender gap.
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  // A tick beat yields no result but keeps the block busy while the level updates; allow margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  localparam logic [WAIT_W-1:0] WAIT_SAT = '1;

  // One expected result of a consume beat.
  typedef struct packed {
    logic [WAIT_W-1:0] wait_ticks;
    logic              granted;
  } verdict_t;

  // Ports of the block; every input starts at a known value.
  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic               kind            = KIND_TICK;
  logic [BYTES_W-1:0] byte_count      = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [WAIT_W-1:0]  wait_ticks;
  logic               granted_now;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [RATE_W-1:0]  rate_kb_per_sec = '0;

  // Bucket model: rate, token level (bytes times ticks per second) and the disabled flag.
  logic [RATE_W-1:0]  sim_rate;
  logic [63:0]        sim_level;
  logic               sim_unlimited;
  verdict_t           verdict_q[$];

  int                 fail_count   = 0;
  int                 quiet_cycles = 0;
  int                 hold_off_len = 0;
  bit                 tx_gaps      = 1'b1;
  bit                 rx_gaps      = 1'b1;

  token_bucket_wait_calculator i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .byte_count      (byte_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .wait_ticks      (wait_ticks),
    .granted_now     (granted_now),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .rate_kb_per_sec (rate_kb_per_sec)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bucket model
  // ---------------------------------------------------------------------------

  // Tokens added by one tick: the rate in bytes per second.
  function automatic logic [63:0] refill_of(input logic [RATE_W-1:0] r);
    return 64'(r) << KB_SHIFT;
  endfunction

  // Two seconds' worth of tokens at rate r.
  function automatic logic [63:0] cap_of(input logic [RATE_W-1:0] r);
    return refill_of(r) * 64'(TPS_DEFAULT) * 64'(BURST_DEFAULT);
  endfunction

  function automatic void bucket_set_rate(input logic [RATE_W-1:0] r);
    sim_rate = r;
    if (r == '0) begin
      // Disable limiting but keep whatever level is held.
      sim_unlimited = 1'b1;
    end else begin
      // Fill when leaving the disabled state, otherwise clip to the new cap.
      if (sim_unlimited || sim_level > cap_of(r)) begin
        sim_level = cap_of(r);
      end
      sim_unlimited = 1'b0;
    end
  endfunction

  function automatic void bucket_take_beat(input logic k, input logic [BYTES_W-1:0] n);
    logic [63:0] cost;
    logic [63:0] deficit;
    logic [63:0] step;
    logic [63:0] ticks;
    verdict_t    v;
    if (k == KIND_TICK) begin
      if (!sim_unlimited) begin
        sim_level = sim_level + refill_of(sim_rate);
        if (sim_level > cap_of(sim_rate)) begin
          sim_level = cap_of(sim_rate);
        end
      end
    end else begin
      v.granted    = 1'b1;
      v.wait_ticks = '0;
      if (!sim_unlimited) begin
        cost = 64'(n) * 64'(TPS_DEFAULT);
        if (sim_level >= cost) begin
          sim_level = sim_level - cost;
        end else begin
          // Short of tokens: empty the bucket and round the wait up, saturating.
          deficit      = cost - sim_level;
          sim_level    = '0;
          step         = refill_of(sim_rate);
          ticks        = (deficit + step - 64'd1) / step;
          v.granted    = 1'b0;
          v.wait_ticks = (ticks > 64'(WAIT_SAT)) ? WAIT_SAT : ticks[WAIT_W-1:0];
        end
      end
      verdict_q.push_back(v);
    end
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge, check results before
  // predicting, so a result is never matched against the beat taken alongside it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      sim_rate      = '0;
      sim_level     = '0;
      sim_unlimited = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: wait %0d granted %0b",
                                 wait_ticks, granted_now));
        end else begin
          want = verdict_q.pop_front();
          if (wait_ticks !== want.wait_ticks) begin
            note_failure($sformatf("wait_ticks: expected %0d, got %0d",
                                   want.wait_ticks, wait_ticks));
          end
          if (granted_now !== want.granted) begin
            note_failure($sformatf("granted_now: expected %0b, got %0b",
                                   want.granted, granted_now));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        bucket_set_rate(rate_kb_per_sec);
      end
      if (in_valid && !in_stall) begin
        bucket_take_beat(kind, byte_count);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("token_bucket_wait_calculator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: a requested long hold takes priority, otherwise random stall bursts while rx_gaps is set.
  // Each branch raises out_stall at a falling edge and lowers it at a later one.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until taken. Valid stays high afterwards so that
  // back-to-back beats never see it dropped and raised in the same step.
  task automatic send_beat(input logic k, input logic [BYTES_W-1:0] n);
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    byte_count <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every pending result, then let a trailing tick finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the rate register; only ever done with the block idle.
  task automatic write_rate(input logic [RATE_W-1:0] r);
    settle();
    cfg_valid       <= 1'b1;
    rate_kb_per_sec <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Byte counts shaped around the current bucket so that grants and waits mix.
  function automatic logic [BYTES_W-1:0] pick_bytes();
    logic [63:0] span;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sim_unlimited || roll >= 85) begin
      return BYTES_W'($urandom());
    end
    if (roll < 8) begin
      return '0;
    end
    if (roll < 12) begin
      // Exactly what is held: granted and leaves the bucket empty.
      return BYTES_W'(sim_level / 64'(TPS_DEFAULT));
    end
    if (roll < 15) begin
      return '1;
    end
    // A tick refills sim_rate bytes; the bucket holds 2048 ticks of them.
    span = (roll < 60) ? (64'(sim_rate) << 1) : (64'(sim_rate) << 12);
    if (span > 64'hFFFF_FFFF) begin
      span = 64'hFFFF_FFFF;
    end
    return BYTES_W'($urandom_range(0, span[31:0]));
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return RATE_W'(1);
      3:       return RATE_W'($urandom_range(2, 16));
      4:       return RATE_W'($urandom_range(17, 4096));
      default: return RATE_W'($urandom());
    endcase
  endfunction

  task automatic random_beat();
    if ($urandom_range(0, 1) == 0) begin
      send_beat(KIND_TICK, BYTES_W'($urandom()));
    end else begin
      send_beat(KIND_CONSUME, pick_bytes());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset limiting is off: everything is granted, ticks do nothing,
  // and a zero rate write keeps it off.
  task automatic test_disabled();
    send_beat(KIND_CONSUME, '0);
    send_beat(KIND_CONSUME, '1);
    send_beat(KIND_TICK, '1);
    send_beat(KIND_CONSUME, 32'h8000_0001);
    write_rate('0);
    send_beat(KIND_CONSUME, '1);
  endtask

  // Slowest rate: the bucket fills to 2048 bytes on leaving the disabled state.
  task automatic test_slowest_rate();
    write_rate(RATE_W'(1));
    send_beat(KIND_CONSUME, 32'd2048);   // drains the full bucket exactly
    send_beat(KIND_CONSUME, '0);
    send_beat(KIND_CONSUME, 32'd1);      // one tick short
    send_beat(KIND_TICK, '0);
    send_beat(KIND_CONSUME, 32'd1);
    send_beat(KIND_CONSUME, '1);         // largest wait the fields allow
    repeat (3) send_beat(KIND_TICK, '0);
    send_beat(KIND_CONSUME, 32'd4);
  endtask

  // Rate changes in every direction: limited to limited (no fill), back to
  // disabled (level kept), leaving disabled (fill), and lowering below the level.
  task automatic test_rate_changes();
    write_rate('1);
    repeat (2) send_beat(KIND_TICK, '0);
    send_beat(KIND_CONSUME, '1);
    write_rate('0);
    send_beat(KIND_CONSUME, '1);
    write_rate(RATE_W'(1000));
    write_rate(RATE_W'(3));
    send_beat(KIND_CONSUME, 32'd6144);   // exactly the clipped cap
    send_beat(KIND_CONSUME, 32'd1);
  endtask

  // Bulk of the run: phases of random beats under a random rate each.
  task automatic test_random_phases();
    for (int p = 0; p < 12; p++) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      write_rate(pick_rate());
      repeat ($urandom_range(60, 120)) random_beat();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while beats keep coming, so the
  // block backs up onto its input; then pause until every result is in.
  task automatic test_receiver_hold();
    write_rate(RATE_W'($urandom_range(1, 64)));
    hold_off_len = HOLD_CYCLES;
    repeat (30) random_beat();
    settle();
  endtask

  // Last part: no idling on either side.
  task automatic test_back_to_back();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_rate(RATE_W'($urandom_range(1, 4096)));
    repeat (150) random_beat();
    write_rate('1);
    repeat (50) random_beat();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled();
    test_slowest_rate();
    test_rate_changes();
    test_random_phases();
    test_receiver_hold();
    test_back_to_back();
    settle();

    if (fail_count == 0) begin
      $display("token_bucket_wait_calculator: match");
    end else begin
      $display("token_bucket_wait_calculator: mismatch");
    end
    $finish;
  end

endmodule
